FILE: src/mmm_pkg.sv
`timescale 1ns / 1ps

package mmm_pkg;

	// sizing
	localparam int MAX_DIM     = 8;
	localparam int ELEM_WIDTH  = 16;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int SA_W        = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(MAX_DIM);
	localparam int DIM_W       = $clog2(MAX_DIM + 1);
	localparam int PROD_W      = 2 * ELEM_WIDTH;

	// fixed field widths
	localparam int CMD_W    = 2;
	localparam int IDX_W    = 6;
	localparam int VAL_W    = 16;
	localparam int ACC_W    = 40;
	localparam int POS_W    = 3;
	localparam int CFG_W    = 4;
	localparam int CFG_IX_W = 2;

	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	// request commands
	localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IX_W-1:0] REG_COLS_B    = 2'd2;

	// tag that travels with each operand pair
	typedef struct packed {
		logic             first;
		logic             lastk;
		logic             last;
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
	} mac_tag_t;

	typedef struct packed {
		logic            we_a;
		logic            we_b;
		logic            rd;
		logic [SA_W-1:0] addr_a;
		logic [SA_W-1:0] addr_b;
		mac_tag_t        tag;
	} ctl_cmd_t;

	typedef struct packed {
		logic busy;
	} dp_status_t;

	// register value 0 acts as 1, above MAX_DIM acts as MAX_DIM
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if ({1'b0, d} > (CFG_W+1)'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(d);
		end
		return r;
	endfunction

endpackage

FILE: src/mmm_ctrl.sv
`timescale 1ns / 1ps

module mmm_ctrl import mmm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [IDX_W-1:0]    elem_index,
	output logic                in_stall,
	output ctl_cmd_t            ctl,
	input  dp_status_t          status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_WAIT
	} state_t;

	state_t           state_q;
	logic [CFG_W-1:0] rows_q, inner_q, colsb_q;
	logic [DIM_W-1:0] ra_q, ka_q, cb_q;
	logic [CNT_W-1:0] row_q, col_q, k_q;
	logic [SA_W-1:0]  a_base_q, a_ptr_q, b_ptr_q;
	logic             stall_q;
	logic             accept;
	logic             idx_ok;
	logic             row_end, col_end, k_end;

	assign accept   = in_valid && !stall_q;
	assign in_stall = stall_q;
	assign idx_ok   = {1'b0, elem_index} < (IDX_W+1)'(STORE_DEPTH);

	assign row_end = DIM_W'(row_q) == ra_q - DIM_W'(1);
	assign col_end = DIM_W'(col_q) == cb_q - DIM_W'(1);
	assign k_end   = DIM_W'(k_q) == ka_q - DIM_W'(1);

	always_comb begin
		ctl.we_a      = accept && cmd == CMD_LOAD_A && idx_ok;
		ctl.we_b      = accept && cmd == CMD_LOAD_B && idx_ok;
		ctl.rd        = state_q == S_RUN;
		ctl.addr_a    = a_ptr_q;
		ctl.addr_b    = b_ptr_q;
		ctl.tag.first = k_q == '0;
		ctl.tag.lastk = k_end;
		ctl.tag.last  = row_end && col_end;
		ctl.tag.row   = row_q;
		ctl.tag.col   = col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_RESET;
			inner_q <= DIM_RESET;
			colsb_q <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_A:    rows_q  <= cfg_wdata;
				REG_INNER_DIM: inner_q <= cfg_wdata;
				REG_COLS_B:    colsb_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			stall_q  <= 1'b0;
			ra_q     <= '0;
			ka_q     <= '0;
			cb_q     <= '0;
			row_q    <= '0;
			col_q    <= '0;
			k_q      <= '0;
			a_base_q <= '0;
			a_ptr_q  <= '0;
			b_ptr_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && cmd == CMD_START) begin
						ra_q     <= clamp_dim(rows_q);
						ka_q     <= clamp_dim(inner_q);
						cb_q     <= clamp_dim(colsb_q);
						row_q    <= '0;
						col_q    <= '0;
						k_q      <= '0;
						a_base_q <= '0;
						a_ptr_q  <= '0;
						b_ptr_q  <= '0;
						stall_q  <= 1'b1;
						state_q  <= S_RUN;
					end
				end
				S_RUN: begin
					if (k_end) begin
						state_q <= S_WAIT;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						a_ptr_q <= a_ptr_q + SA_W'(1);
						b_ptr_q <= b_ptr_q + SA_W'(cb_q);
					end
				end
				S_WAIT: begin
					// one element in flight at a time: wait for it to reach the output
					if (!status.busy) begin
						if (row_end && col_end) begin
							stall_q <= 1'b0;
							state_q <= S_IDLE;
						end else if (col_end) begin
							row_q    <= row_q + CNT_W'(1);
							col_q    <= '0;
							k_q      <= '0;
							a_base_q <= a_base_q + SA_W'(ka_q);
							a_ptr_q  <= a_base_q + SA_W'(ka_q);
							b_ptr_q  <= '0;
							state_q  <= S_RUN;
						end else begin
							col_q   <= col_q + CNT_W'(1);
							k_q     <= '0;
							a_ptr_q <= a_base_q;
							b_ptr_q <= SA_W'(col_q) + SA_W'(1);
							state_q <= S_RUN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_read_while_open: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd |-> stall_q)
		else $error("store read while requests are open");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.we_a || ctl.we_b) |-> state_q == S_IDLE)
		else $error("store write during multiply");

	a_wait_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT && !status.busy && row_end && col_end)
		|=> (state_q == S_IDLE && !stall_q))
		else $error("run did not close after last element");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && accept && cmd == CMD_START) |=> (ctl.rd && k_q == '0))
		else $error("start request did not begin a walk");

endmodule

FILE: src/mmm_dpath.sv
`timescale 1ns / 1ps

module mmm_dpath import mmm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_cmd_t                 ctl,
	input  logic [IDX_W-1:0]         elem_index,
	input  logic signed [VAL_W-1:0]  elem_value,
	output dp_status_t               status,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [ACC_W-1:0]  prod_value,
	output logic [POS_W-1:0]         out_row,
	output logic [POS_W-1:0]         out_col,
	output logic                     last
);

	logic [ELEM_WIDTH-1:0]    mem_a [STORE_DEPTH];
	logic [ELEM_WIDTH-1:0]    mem_b [STORE_DEPTH];
	logic signed [31:0]       val_ext;
	logic [ELEM_WIDTH-1:0]    wr_val;
	logic [SA_W-1:0]          wr_addr;

	logic                     v_s1, v_s2, done_q;
	logic [ELEM_WIDTH-1:0]    a_s1, b_s1;
	mac_tag_t                 tag_s1, tag_s2, tag_q;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  acc_base;
	logic                     out_free;

	// narrow stores wrap the value as a signed number
	assign val_ext = 32'(elem_value);
	assign wr_val  = val_ext[ELEM_WIDTH-1:0];
	assign wr_addr = elem_index[SA_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.we_a) begin
			mem_a[wr_addr] <= wr_val;
		end
		if (ctl.we_b) begin
			mem_b[wr_addr] <= wr_val;
		end
		if (ctl.rd) begin
			a_s1   <= mem_a[ctl.addr_a];
			b_s1   <= mem_b[ctl.addr_b];
			tag_s1 <= ctl.tag;
		end
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= $signed(a_s1) * $signed(b_s1);
			tag_s2  <= tag_s1;
		end
	end

	assign prod_ext = ACC_W'(prod_s2);
	assign acc_base = tag_s2.first ? '0 : acc_q;
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= acc_base + prod_ext;
			tag_q <= tag_s2;
		end
		if (done_q && out_free) begin
			prod_value <= acc_q;
			out_row    <= POS_W'(tag_q.row);
			out_col    <= POS_W'(tag_q.col);
			last       <= tag_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			done_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= ctl.rd;
			v_s2 <= v_s1;
			if (v_s2 && tag_s2.lastk) begin
				done_q <= 1'b1;
			end else if (done_q && out_free) begin
				done_q <= 1'b0;
			end
			if (done_q && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign status.busy = v_s1 || v_s2 || done_q;

	a_done_held: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && out_valid && out_stall) |=> done_q)
		else $error("finished sum lost while output stalled");

	a_sum_completes: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && tag_s2.lastk) |=> done_q)
		else $error("final product did not complete the sum");

endmodule

FILE: src/matrix_matrix_multiply.sv
`timescale 1ns / 1ps

// general matrix multiply C = A * B with signed Q8.8 elements; exact Q16.16 products
// sum in a 40-bit (Q24.16) accumulator. load requests (cmd load A / load B) write one
// element at a row-major index into an on-chip store and are taken one per cycle
// while the block is idle; indexes beyond the store are dropped. a start request
// walks C in row-major order and returns one result per element, last set on the
// final one. each element reads inner_dim operand pairs from the two stores (one read
// port each, registered) and passes them through the multiply and accumulate stages
// into the output register; the walk reads the next element only once that sum has
// reached the output register, so a stalled output holds it up. input stall stays
// high for the whole walk. dimension registers (index 0 rows_a, 1 inner_dim, 2
// cols_b) reset to 8; 0 acts as 1 and values above 8 act as 8. they are sampled when
// a start request is taken. store contents are undefined until written.

module matrix_matrix_multiply import mmm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_we,
	input  logic [CFG_IX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]         cfg_wdata,
	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [IDX_W-1:0]         elem_index,
	input  logic signed [VAL_W-1:0]  elem_value,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [ACC_W-1:0]  prod_value,
	output logic [POS_W-1:0]         out_row,
	output logic [POS_W-1:0]         out_col,
	output logic                     last
);

	ctl_cmd_t   ctl;
	dp_status_t status;

	// sequencer: request decode, dimension registers, row/column/inner walk
	mmm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.cmd        (cmd),
		.elem_index (elem_index),
		.in_stall   (in_stall),
		.ctl        (ctl),
		.status     (status)
	);

	// stores, multiplier, accumulator and output register
	mmm_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.elem_index (elem_index),
		.elem_value (elem_value),
		.status     (status),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.prod_value (prod_value),
		.out_row    (out_row),
		.out_col    (out_col),
		.last       (last)
	);

endmodule

FILE: test/tb_matrix_matrix_multiply.sv
`timescale 1ns / 1ps

module tb_matrix_matrix_multiply;
	import mmm_pkg::*;

	// command code the block does not use
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int SETTLE_CYCLES   = 16;    // longest element walk plus the mac pipeline
	localparam int HOLD_CYCLES     = 300;   // long result hold-off to fill the block
	localparam int IDLE_LIMIT      = 3000;  // cycles with no transfer before giving up
	localparam int RANDOM_REQUESTS = 100;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// one element of C as it should leave the block
	typedef struct packed {
		logic signed [ACC_W-1:0] prod;
		logic [POS_W-1:0]        row;
		logic [POS_W-1:0]        col;
		logic                    last;
	} c_elem_t;

	// one line of the directed table: either a new set of dimensions or a request
	typedef struct packed {
		logic                    is_dims;
		logic [CFG_W-1:0]        dim_r;
		logic [CFG_W-1:0]        dim_k;
		logic [CFG_W-1:0]        dim_c;
		logic [CMD_W-1:0]        cmd;
		logic [IDX_W-1:0]        idx;
		logic [VAL_W-1:0]        value;
		logic                    has_typed;
		logic signed [ACC_W-1:0] typed;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]        cfg_wdata;
	logic                    in_valid;
	logic                    in_stall;
	logic [CMD_W-1:0]        cmd;
	logic [IDX_W-1:0]        elem_index;
	logic signed [VAL_W-1:0] elem_value;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [ACC_W-1:0] prod_value;
	logic [POS_W-1:0]        out_row;
	logic [POS_W-1:0]        out_col;
	logic                    last;

	matrix_matrix_multiply dut (.*);

	// own copy of the matrix stores and dimension registers
	logic signed [VAL_W-1:0] a_mat [STORE_DEPTH];
	logic signed [VAL_W-1:0] b_mat [STORE_DEPTH];
	logic [CFG_W-1:0]        rows_reg;
	logic [CFG_W-1:0]        inner_reg;
	logic [CFG_W-1:0]        cols_reg;
	c_elem_t                 pending_elems[$];

	// which store entries the stimulus has written so far
	bit a_written [STORE_DEPTH];
	bit b_written [STORE_DEPTH];

	idle_mode_t idle_mode     = IDLE_NONE;
	int         hold_requests = 0;
	int         error_count   = 0;
	int         requests_sent = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// percentage of cycles in which each side idles in the current phase
	function automatic int idle_pct(input bit receiver_side);
		case (idle_mode)
		IDLE_SENDER:   return receiver_side ? 0 : 60;
		IDLE_RECEIVER: return receiver_side ? 60 : 0;
		IDLE_BOTH:     return 38;
		default:       return 0;
		endcase
	endfunction

	// dimension as the block uses it: zero acts as one, above the maximum saturates
	function automatic int eff_dim(input logic [CFG_W-1:0] d);
		if (d == '0)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return int'(d);
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= 40)
			$display("%0t mismatch: %s", $time, what);
	endtask

	// update the stores on a load, or work out every element of C on a start
	task automatic predict_request(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] ix,
			input logic signed [VAL_W-1:0] v, input logic has_typed,
			input logic signed [ACC_W-1:0] typed);
		int ra, ka, cb, r, col, k;
		logic signed [ACC_W-1:0] acc;
		c_elem_t elem;
		case (c)
		CMD_LOAD_A: begin
			if (ix < STORE_DEPTH)
				a_mat[ix] = v;
		end
		CMD_LOAD_B: begin
			if (ix < STORE_DEPTH)
				b_mat[ix] = v;
		end
		CMD_START: begin
			ra = eff_dim(rows_reg);
			ka = eff_dim(inner_reg);
			cb = eff_dim(cols_reg);
			for (r = 0; r < ra; r++) begin
				for (col = 0; col < cb; col++) begin
					acc = '0;
					// signed operands widen to the accumulator before the multiply
					for (k = 0; k < ka; k++)
						acc = acc + a_mat[r * ka + k] * b_mat[k * cb + col];
					elem.prod = (has_typed && ra * cb == 1) ? typed : acc;
					elem.row  = POS_W'(r);
					elem.col  = POS_W'(col);
					elem.last = (r == ra - 1) && (col == cb - 1);
					pending_elems.push_back(elem);
				end
			end
		end
		default: ;
		endcase
	endtask

	// a start may only go out once every entry it reads has been loaded
	function automatic bit stores_ready();
		int ra, ka, cb, i;
		ra = eff_dim(rows_reg);
		ka = eff_dim(inner_reg);
		cb = eff_dim(cols_reg);
		for (i = 0; i < ra * ka; i++)
			if (!a_written[i])
				return 1'b0;
		for (i = 0; i < ka * cb; i++)
			if (!b_written[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [VAL_W-1:0] rand_elem();
		case ($urandom_range(0, 7))
		0:       return 16'h7FFF;
		1:       return 16'h8000;
		2:       return 16'h0000;
		default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_dim();
		if ($urandom_range(0, 9) < 7)
			return CFG_W'($urandom_range(1, 3));
		return CFG_W'($urandom_range(0, 15));
	endfunction

	// offer one request, hold it until taken, then predict from it
	task automatic send_request(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] ix,
			input logic [VAL_W-1:0] v, input logic has_typed,
			input logic signed [ACC_W-1:0] typed);
		while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		elem_index <= ix;
		elem_value <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_request(c, ix, v, has_typed, typed);
		if (c == CMD_LOAD_A)
			a_written[ix] = 1'b1;
		else if (c == CMD_LOAD_B)
			b_written[ix] = 1'b1;
		if (c != CMD_UNUSED)
			requests_sent++;
	endtask

	// stop sending, wait for every element of C, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_elems.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
			input logic [CFG_W-1:0] cb);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROWS_A;
		cfg_wdata <= r;
		@(posedge clk);
		rows_reg = r;
		cfg_index <= REG_INNER_DIM;
		cfg_wdata <= k;
		@(posedge clk);
		inner_reg = k;
		cfg_index <= REG_COLS_B;
		cfg_wdata <= cb;
		@(posedge clk);
		cols_reg = cb;
		cfg_we <= 1'b0;
	endtask

	// unused command or a stray load anywhere in the stores
	task automatic send_noise();
		if ($urandom_range(0, 1))
			send_request(CMD_UNUSED, IDX_W'($urandom), rand_elem(), 1'b0, '0);
		else
			send_request($urandom_range(0, 1) ? CMD_LOAD_A : CMD_LOAD_B, IDX_W'($urandom),
				rand_elem(), 1'b0, '0);
	endtask

	// load the operands in shuffled order, then start; a broken sequence loads only some
	task automatic run_sequence(input bit complete);
		int ra, ka, cb, j, pick, tmp, keep;
		int order[$];
		ra = eff_dim(rows_reg);
		ka = eff_dim(inner_reg);
		cb = eff_dim(cols_reg);
		for (j = 0; j < ra * ka; j++)
			order.push_back(j);
		for (j = 0; j < ka * cb; j++)
			order.push_back(STORE_DEPTH + j);
		for (j = order.size() - 1; j > 0; j--) begin
			pick = $urandom_range(0, j);
			tmp = order[j];
			order[j] = order[pick];
			order[pick] = tmp;
		end
		if (!complete) begin
			keep = $urandom_range(0, order.size() / 2);
			while (order.size() > keep)
				void'(order.pop_back());
		end
		for (j = 0; j < order.size(); j++) begin
			if ($urandom_range(0, 9) == 0)
				send_noise();
			if (order[j] < STORE_DEPTH)
				send_request(CMD_LOAD_A, IDX_W'(order[j]), rand_elem(), 1'b0, '0);
			else
				send_request(CMD_LOAD_B, IDX_W'(order[j] - STORE_DEPTH), rand_elem(), 1'b0, '0);
		end
		// start falls back on older store contents when those cover the read
		if (stores_ready())
			send_request(CMD_START, IDX_W'($urandom), VAL_W'($urandom), 1'b0, '0);
	endtask

	function automatic stim_row_t dims_row(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
			input logic [CFG_W-1:0] cb);
		stim_row_t s;
		s = '0;
		s.is_dims = 1'b1;
		s.dim_r   = r;
		s.dim_k   = k;
		s.dim_c   = cb;
		return s;
	endfunction

	function automatic stim_row_t req_row(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] ix,
			input logic [VAL_W-1:0] v);
		stim_row_t s;
		s = '0;
		s.cmd   = c;
		s.idx   = ix;
		s.value = v;
		return s;
	endfunction

	// single-element start whose sum is plain from the operands
	function automatic stim_row_t typed_start(input logic signed [ACC_W-1:0] typed);
		stim_row_t s;
		s = req_row(CMD_START, '0, '0);
		s.has_typed = 1'b1;
		s.typed     = typed;
		return s;
	endfunction

	// result side: random stalls by phase, plus long hold-offs counted here
	initial begin
		int hold_left;
		int holds_done;
		hold_left  = 0;
		holds_done = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_done != hold_requests) begin
				holds_done = hold_requests;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
			end
		end
	end

	// every accepted element of C against the oldest one predicted
	always @(posedge clk) begin
		c_elem_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_elems.size() == 0) begin
				report_mismatch($sformatf("unexpected element row %0d col %0d value %0d",
					out_row, out_col, prod_value));
			end else begin
				want = pending_elems.pop_front();
				if (prod_value !== want.prod)
					report_mismatch($sformatf("row %0d col %0d value %0d, wanted %0d",
						want.row, want.col, prod_value, want.prod));
				if (out_row !== want.row)
					report_mismatch($sformatf("row %0d, wanted %0d", out_row, want.row));
				if (out_col !== want.col)
					report_mismatch($sformatf("col %0d, wanted %0d", out_col, want.col));
				if (last !== want.last)
					report_mismatch($sformatf("row %0d col %0d last %0b, wanted %0b",
						want.row, want.col, last, want.last));
			end
		end
	end

	// watchdog: gives up after a long stretch with no transfer on any port
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)
					|| cfg_we === 1'b1 || arst_n !== 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t timeout: nothing moved for %0d cycles", $time, IDLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		stim_row_t directed_rows[$];
		stim_row_t row;
		int phase;
		int seq_count;
		int s;
		logic [CFG_W-1:0] dr, dk, dc;

		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_ROWS_A;
		cfg_wdata  <= '0;
		in_valid   <= 1'b0;
		cmd        <= CMD_LOAD_A;
		elem_index <= '0;
		elem_value <= '0;
		rows_reg   = DIM_RESET;
		inner_reg  = DIM_RESET;
		cols_reg   = DIM_RESET;

		// 1x1x1 with rows_a at zero: max times max, min times min and mixed-sign products
		directed_rows.push_back(dims_row(4'd0, 4'd1, 4'd1));
		directed_rows.push_back(req_row(CMD_LOAD_A, 6'd0, 16'h7FFF));
		directed_rows.push_back(req_row(CMD_LOAD_B, 6'd0, 16'h7FFF));
		directed_rows.push_back(typed_start(40'sh3FFF0001));
		directed_rows.push_back(req_row(CMD_LOAD_A, 6'd0, 16'h8000));
		directed_rows.push_back(req_row(CMD_LOAD_B, 6'd0, 16'h8000));
		directed_rows.push_back(typed_start(40'sh40000000));
		directed_rows.push_back(req_row(CMD_LOAD_B, 6'd0, 16'h7FFF));
		directed_rows.push_back(typed_start(-40'sd1073709056));
		// unused command and loads at the top index must leave the product alone
		directed_rows.push_back(req_row(CMD_UNUSED, 6'd63, 16'hFFFF));
		directed_rows.push_back(req_row(CMD_LOAD_A, 6'd63, 16'hFFFF));
		directed_rows.push_back(req_row(CMD_LOAD_B, 6'd63, 16'h0001));
		directed_rows.push_back(typed_start(-40'sd1073709056));
		// short dot products over one row and over one column
		directed_rows.push_back(dims_row(4'd1, 4'd2, 4'd2));
		directed_rows.push_back(req_row(CMD_LOAD_A, 6'd1, 16'h0100));
		directed_rows.push_back(req_row(CMD_LOAD_B, 6'd1, 16'h0180));
		directed_rows.push_back(req_row(CMD_LOAD_B, 6'd2, 16'h0200));
		directed_rows.push_back(req_row(CMD_LOAD_B, 6'd3, 16'hFF00));
		directed_rows.push_back(req_row(CMD_START, 6'd0, 16'h0000));
		directed_rows.push_back(dims_row(4'd2, 4'd1, 4'd1));
		directed_rows.push_back(req_row(CMD_START, 6'd0, 16'h0000));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_dims) begin
				drain();
				set_dims(row.dim_r, row.dim_k, row.dim_c);
			end else begin
				send_request(row.cmd, row.idx, row.value, row.has_typed, row.typed);
			end
		end

		// random phases, each with its own dimensions and idling pattern
		requests_sent = 0;
		for (phase = 0; requests_sent < RANDOM_REQUESTS || phase < 4; phase++) begin
			drain();
			case (phase)
			0: begin
				// 8x1x8 from saturated registers: the longest run of results
				dr = 4'd15;
				dk = 4'd1;
				dc = 4'd15;
			end
			1: begin
				dr = 4'd1;
				dk = 4'd15;
				dc = 4'd1;
			end
			2: begin
				dr = 4'd2;
				dk = 4'd0;
				dc = 4'd8;
			end
			default: begin
				dr = rand_dim();
				dk = rand_dim();
				dc = rand_dim();
			end
			endcase
			idle_mode = idle_mode_t'(phase % 4);
			set_dims(dr, dk, dc);
			// hold the result side off while requests keep coming, so the block backs up
			if (phase == 0)
				hold_requests++;
			seq_count = $urandom_range(1, 3);
			for (s = 0; s < seq_count && (s == 0 || requests_sent < RANDOM_REQUESTS); s++) begin
				run_sequence($urandom_range(0, 4) != 0);
				if ($urandom_range(0, 5) == 0)
					drain();
			end
		end
		drain();

		if (pending_elems.size() != 0)
			report_mismatch($sformatf("%0d elements never arrived", pending_elems.size()));
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
